// ----- sv/calendar_clock_counter_macros.svh -----
// ----------------------------------------------------------------------------
// Calendar clock counter assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_COUNTER_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_MACROS_SVH

`ifndef SYNTH
`define CAL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar clock counter assertion failed");
`define CAL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar clock counter assertion failed");
`else
`define CAL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CAL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- sv/cal_pkg.sv -----
// ----------------------------------------------------------------------------
// Calendar clock counter package
// Item types, command and error codes, calendar constants.
// ----------------------------------------------------------------------------
package cal_pkg;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_SET_TIME = 2'd1,
      CMD_SET_DATE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ERR_OK     = 3'd0,
      ERR_YEAR   = 3'd1,
      ERR_MONTH  = 3'd2,
      ERR_DAY    = 3'd3,
      ERR_HOUR   = 3'd4,
      ERR_MINUTE = 3'd5,
      ERR_SECOND = 3'd6
   } err_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [4:0]  new_hour;
      logic [5:0]  new_minute;
      logic [5:0]  new_second;
      logic [3:0]  new_month;
      logic [4:0]  new_day;
      logic [15:0] new_year;
   } req_type;

   typedef struct packed {
      logic [5:0]  cur_second;
      logic [5:0]  cur_minute;
      logic [4:0]  cur_hour;
      logic [4:0]  cur_day;
      logic [3:0]  cur_month;
      logic [15:0] cur_year;
      logic [3:0]  hour_twelve;
      logic        is_pm;
      logic [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
   } cal_time_type;

   localparam logic [5:0]  SEC_MAX   = 6'd59;
   localparam logic [5:0]  MIN_MAX   = 6'd59;
   localparam logic [4:0]  HOUR_MAX  = 5'd23;
   localparam logic [4:0]  NOON      = 5'd12;
   localparam logic [3:0]  MONTH_MAX = 4'd12;
   localparam logic [3:0]  FEBRUARY  = 4'd2;
   localparam logic [15:0] RST_YEAR  = 16'd2000;

   // multiplicative inverse of 25 modulo 2^32
   localparam logic [31:0] INV25 = 32'hC28F5C29;

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] n;
      unique case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
         FEBRUARY:                                   n = leap ? 5'd29 : 5'd28;
         default:                                    n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- sv/cal_leap.sv -----
// ----------------------------------------------------------------------------
// Gregorian leap year detect
// Divisibility by 25 via modular inverse multiply; 4 and 16 by low bits.
// ----------------------------------------------------------------------------
module cal_leap #(
   parameter int W = 16
) (
   input  logic [W-1:0] year,
   output logic         leap
);
   import cal_pkg::*;

   localparam logic [W-1:0] INV      = INV25[W-1:0];
   localparam logic [W-1:0] ALL_ONES = '1;
   localparam logic [W-1:0] LIMIT    = ALL_ONES / W'(25);

   logic [W-1:0] prod;
   logic         div25;

   assign prod  = year * INV;
   assign div25 = (prod <= LIMIT);
   assign leap  = (year[1:0] == 2'b00 && !div25) || (year[3:0] == 4'b0000 && div25);

endmodule

// ----- sv/cal_step.sv -----
// ----------------------------------------------------------------------------
// Calendar step logic
// Next clock/date state and result item for one command.
// ----------------------------------------------------------------------------
module cal_step #(
   parameter int YEAR_WIDTH = 16
) (
   input  cal_pkg::req_type       req,
   input  cal_pkg::cal_time_type  cur,
   input  logic [YEAR_WIDTH-1:0]  cur_year,
   output cal_pkg::cal_time_type  nxt,
   output logic [YEAR_WIDTH-1:0]  nxt_year,
   output cal_pkg::rsp_type       rsp
);
   import cal_pkg::*;

   localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = '1;

   logic       leap_cur;
   logic       leap_new;
   logic [4:0] days_cur;
   logic [4:0] days_new;
   logic       year_bad;
   err_type    err;
   logic [3:0] h12;

   cal_leap #(.W(YEAR_WIDTH)) u_leap_cur (.year(cur_year), .leap(leap_cur));
   cal_leap #(.W(16))         u_leap_new (.year(req.new_year), .leap(leap_new));

   assign days_cur = month_days(cur.month, leap_cur);
   assign days_new = month_days(req.new_month, leap_new);
   assign year_bad = (req.new_year == 16'd0) || ((req.new_year >> YEAR_WIDTH) != 16'd0);

   always_comb begin
      nxt      = cur;
      nxt_year = cur_year;
      err      = ERR_OK;
      case (req.cmd)
         CMD_TICK: begin
            if (cur.second >= SEC_MAX) begin
               nxt.second = '0;
               if (cur.minute >= MIN_MAX) begin
                  nxt.minute = '0;
                  if (cur.hour >= HOUR_MAX) begin
                     nxt.hour = '0;
                     if (cur.day >= days_cur) begin
                        nxt.day = 5'd1;
                        if (cur.month >= MONTH_MAX) begin
                           nxt.month = 4'd1;
                           if (cur_year != YEAR_MAX) begin
                              nxt_year = cur_year + YEAR_WIDTH'(1);
                           end
                        end else begin
                           nxt.month = cur.month + 4'd1;
                        end
                     end else begin
                        nxt.day = cur.day + 5'd1;
                     end
                  end else begin
                     nxt.hour = cur.hour + 5'd1;
                  end
               end else begin
                  nxt.minute = cur.minute + 6'd1;
               end
            end else begin
               nxt.second = cur.second + 6'd1;
            end
         end
         CMD_SET_TIME: begin
            if (req.new_hour > HOUR_MAX) begin
               err = ERR_HOUR;
            end else if (req.new_minute > MIN_MAX) begin
               err = ERR_MINUTE;
            end else if (req.new_second > SEC_MAX) begin
               err = ERR_SECOND;
            end else begin
               nxt.hour   = req.new_hour;
               nxt.minute = req.new_minute;
               nxt.second = req.new_second;
            end
         end
         CMD_SET_DATE: begin
            if (year_bad) begin
               err = ERR_YEAR;
            end else if (req.new_month == 4'd0 || req.new_month > MONTH_MAX) begin
               err = ERR_MONTH;
            end else if (req.new_day == 5'd0 || req.new_day > days_new) begin
               err = ERR_DAY;
            end else begin
               nxt_year  = YEAR_WIDTH'(req.new_year);
               nxt.month = req.new_month;
               nxt.day   = req.new_day;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (nxt.hour == 5'd0) begin
         h12 = 4'd12;
      end else if (nxt.hour > NOON) begin
         h12 = 4'(nxt.hour - NOON);
      end else begin
         h12 = nxt.hour[3:0];
      end
   end

   assign rsp.cur_second  = nxt.second;
   assign rsp.cur_minute  = nxt.minute;
   assign rsp.cur_hour    = nxt.hour;
   assign rsp.cur_day     = nxt.day;
   assign rsp.cur_month   = nxt.month;
   assign rsp.cur_year    = 16'(nxt_year);
   assign rsp.hour_twelve = h12;
   assign rsp.is_pm       = (nxt.hour >= NOON);
   assign rsp.error_code  = err;

endmodule

// ----- sv/calendar_clock_counter.sv -----
// Flow: an accepted item is held in the input register, and its result is written to the
// result register when the item advances, that is when the result register is empty or not stalled.
// Throughput: one item per cycle while rsp_stall does not hold the result; the limit is the
// combinational next-state path through the leap-year multiply and day-of-month compare.
// Reset (synchronous, active high) sets 00:00:00, January 1, 2000 and empties
// both stages.
// ----------------------------------------------------------------------------
// Calendar clock counter
// Real-time clock/calendar with tick, set-time and set-date items.
// ----------------------------------------------------------------------------
`include "calendar_clock_counter_macros.svh"

module calendar_clock_counter #(
   parameter int YEAR_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cal_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cal_pkg::rsp_type rsp_item
);
   import cal_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   req_type               in_item_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_item_ff;
   cal_time_type          clk_ff, clk_in;
   logic [YEAR_WIDTH-1:0] year_ff, year_in;
   rsp_type               step_rsp;
   logic                  advance;
   logic                  accept;

   cal_step #(.YEAR_WIDTH(YEAR_WIDTH)) u_step (
      .req      (in_item_ff),
      .cur      (clk_ff),
      .cur_year (year_ff),
      .nxt      (clk_in),
      .nxt_year (year_in),
      .rsp      (step_rsp)
   );

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         clk_ff       <= '{second: 6'd0, minute: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd1};
         year_ff      <= YEAR_WIDTH'(RST_YEAR);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            clk_ff  <= clk_in;
            year_ff <= year_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   `CAL_ASSERT_IMP(a_rsp_tracks_state, clock, reset, out_valid_ff, out_item_ff.cur_second == clk_ff.second && out_item_ff.cur_day == clk_ff.day && out_item_ff.cur_month == clk_ff.month)
   `CAL_ASSERT_NXT(a_idle_holds_state, clock, reset, !advance, $stable(clk_ff) && $stable(year_ff))
   `CAL_ASSERT_NXT(a_error_holds_state, clock, reset, advance && step_rsp.error_code != ERR_OK, $stable(clk_ff) && $stable(year_ff))
   `CAL_ASSERT_NXT(a_tick_counts_second, clock, reset, advance && in_item_ff.cmd == CMD_TICK && clk_ff.second != SEC_MAX, clk_ff.second == $past(clk_ff.second) + 6'd1)

endmodule
